@@ sv/hidfd_pkg.sv @@
// Shared types and constants for the HID command frame deframer.
`default_nettype none

package hidfd_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte SYNC_BYTE     = 8'hA5;
    localparam t_byte TYPE_KEYBOARD = 8'h4B;
    localparam t_byte TYPE_MOUSE    = 8'h4D;

    localparam int CAP_DEPTH = 7;
    localparam int NUM_KEYS  = 6;

    localparam logic [2:0] ST_KEYBOARD = 3'd0;
    localparam logic [2:0] ST_MOUSE    = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_CSUM_ERR = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]                status;
        t_byte                     mod_or_buttons;
        t_byte [NUM_KEYS-1:0]      keys;
        logic signed [7:0]         delta_x;
        logic signed [7:0]         delta_y;
    } t_result;

endpackage

`default_nettype wire

@@ sv/hidfd_if.sv @@
// Valid/ready channel interfaces for received bytes and decoded reports.
`default_nettype none

interface hidfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hidfd_rpt_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [7:0]        mod_or_buttons;
    logic [7:0]        key_0;
    logic [7:0]        key_1;
    logic [7:0]        key_2;
    logic [7:0]        key_3;
    logic [7:0]        key_4;
    logic [7:0]        key_5;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;

    modport source (
        output valid, output status, output mod_or_buttons,
        output key_0, output key_1, output key_2, output key_3, output key_4, output key_5,
        output delta_x, output delta_y, input ready
    );
    modport sink (
        input valid, input status, input mod_or_buttons,
        input key_0, input key_1, input key_2, input key_3, input key_4, input key_5,
        input delta_x, input delta_y, output ready
    );
endinterface

`default_nettype wire

@@ sv/hidfd_in_stage.sv @@
// Input register: holds one received byte until the parser consumes it.
`default_nettype none

module hidfd_in_stage
    import hidfd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    hidfd_byte_if.sink  i_rx,
    input  wire         i_advance,
    output logic        o_vld,
    output t_byte       o_byte
);

    logic  r_vld;
    logic  n_vld;
    t_byte r_byte;
    logic  w_take;

    assign i_rx.ready = !r_vld || i_advance;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_comb begin
        n_vld = r_vld;
        if (w_take) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

`default_nettype wire

@@ sv/hidfd_parse.sv @@
// Frame parser: byte counter, running checksum, payload capture and report decode.
`default_nettype none

module hidfd_parse
    import hidfd_pkg::*;
#(
    parameter int MAX_FRAME = 128,
    parameter int KEY_LIMIT = 6
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_step,
    input  t_byte    i_byte,
    output logic     o_res_vld,
    output t_result  o_res
);

    localparam int CNT_W = $clog2(MAX_FRAME);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_byte            r_type;
    t_byte            n_type;
    t_byte            r_len;
    t_byte            n_len;
    t_byte            r_sum;
    t_byte            n_sum;
    t_byte            r_cap [CAP_DEPTH];
    t_byte            n_cap [CAP_DEPTH];
    logic [8:0]       w_pos;
    logic [8:0]       w_taken;
    logic [8:0]       w_len4;
    t_byte            w_sum;

    assign w_pos   = 9'(r_cnt);
    assign w_taken = w_pos + 9'd1;
    assign w_len4  = {1'b0, r_len} + 9'd4;
    assign w_sum   = r_sum + i_byte;

    always_comb begin
        n_cnt     = r_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_sum     = r_sum;
        n_cap     = r_cap;
        o_res_vld = 1'b0;
        o_res     = '0;
        if (i_step) begin
            if (r_cnt == '0) begin
                if (i_byte == SYNC_BYTE) begin
                    n_cnt  = CNT_W'(1);
                    n_type = '0;
                    n_len  = '0;
                    n_sum  = '0;
                    for (int i = 0; i < CAP_DEPTH; i++) begin
                        n_cap[i] = '0;
                    end
                end
            end else begin
                n_sum = w_sum;
                if (w_pos == 9'd1) begin
                    n_type = i_byte;
                end
                if (w_pos == 9'd2) begin
                    n_len = i_byte;
                end
                for (int i = 0; i < CAP_DEPTH; i++) begin
                    if (w_pos == 9'(i + 3) && 8'(i) < r_len) begin
                        n_cap[i] = i_byte;
                    end
                end
                if (w_taken == w_len4) begin
                    o_res_vld = 1'b1;
                    n_cnt     = '0;
                    if (w_sum != '0) begin
                        o_res.status = ST_CSUM_ERR;
                    end else if (r_type == TYPE_KEYBOARD) begin
                        // keys past the payload read as zero from the cleared capture
                        o_res.status         = ST_KEYBOARD;
                        o_res.mod_or_buttons = r_cap[0];
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (k < KEY_LIMIT) begin
                                o_res.keys[k] = r_cap[k+1];
                            end
                        end
                    end else if (r_type == TYPE_MOUSE) begin
                        o_res.status         = ST_MOUSE;
                        o_res.mod_or_buttons = r_cap[0];
                        o_res.delta_x        = $signed(r_cap[1]);
                        o_res.delta_y        = $signed(r_cap[2]);
                    end else begin
                        o_res.status = ST_IGNORED;
                    end
                end else if (w_taken >= 9'(MAX_FRAME)) begin
                    o_res_vld    = 1'b1;
                    o_res.status = ST_OVERFLOW;
                    n_cnt        = '0;
                end else begin
                    n_cnt = w_taken[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_len  <= n_len;
        r_sum  <= n_sum;
        r_cap  <= n_cap;
    end

endmodule

`default_nettype wire

@@ sv/hidfd_out_stage.sv @@
// Result register: holds one report until the downstream side takes it.
`default_nettype none

module hidfd_out_stage
    import hidfd_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_load,
    input  t_result       i_res,
    hidfd_rpt_if.source   o_rpt,
    output logic          o_free
);

    logic    r_vld;
    logic    n_vld;
    t_result r_res;

    assign o_free = !r_vld || o_rpt.ready;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (o_rpt.ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_rpt.valid          = r_vld;
    assign o_rpt.status         = r_res.status;
    assign o_rpt.mod_or_buttons = r_res.mod_or_buttons;
    assign o_rpt.key_0          = r_res.keys[0];
    assign o_rpt.key_1          = r_res.keys[1];
    assign o_rpt.key_2          = r_res.keys[2];
    assign o_rpt.key_3          = r_res.keys[3];
    assign o_rpt.key_4          = r_res.keys[4];
    assign o_rpt.key_5          = r_res.keys[5];
    assign o_rpt.delta_x        = r_res.delta_x;
    assign o_rpt.delta_y        = r_res.delta_y;

endmodule

`default_nettype wire

@@ sv/hid_command_frame_deframer_core.sv @@
// Top level of the HID command frame deframer.
//
// i_rx carries received serial bytes, one per transfer. The block hunts for
// the sync byte 0xA5, then takes type, length L, L payload bytes and a
// checksum byte. For each finished frame, checksum failure or overflow it
// sends one report transfer on o_rpt: keyboard, mouse, ignored type,
// checksum fail or overflow drop. All other bytes give no report.
// Throughput: one byte per cycle while o_rpt is not stalled. A byte passes
// an input register, then the counter/sum/capture logic, then the result
// register; the report for the byte that ends a frame is loaded into the
// result register when that byte leaves the input register.
// Reset clears the input and result valid flags and returns the parser to
// hunting; capture registers are cleared at each sync byte that starts a frame.
// When o_rpt is stalled with a report pending, the byte in the input
// register is held and i_rx.ready drops once that register is full;
// nothing is lost and bytes continue as soon as the report is taken.
`default_nettype none

module hid_command_frame_deframer_core
    import hidfd_pkg::*;
#(
    parameter int MAX_FRAME = 128,
    parameter int KEY_LIMIT = 6
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    hidfd_byte_if.sink    i_rx,
    hidfd_rpt_if.source   o_rpt
);

    logic    w_in_vld;
    t_byte   w_in_byte;
    logic    w_advance;
    logic    w_step;
    logic    w_res_vld;
    t_result w_res;

    assign w_step = w_in_vld && w_advance;

    hidfd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_vld     (w_in_vld),
        .o_byte    (w_in_byte)
    );

    hidfd_parse #(
        .MAX_FRAME (MAX_FRAME),
        .KEY_LIMIT (KEY_LIMIT)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (w_in_byte),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    hidfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_vld),
        .i_res   (w_res),
        .o_rpt   (o_rpt),
        .o_free  (w_advance)
    );

endmodule

`default_nettype wire

@@ sv/hidfd_checker.sv @@
// Port-level checks on the deframer report channel, bound to the top level.
`default_nettype none

module hidfd_checker
    import hidfd_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_status,
    input wire [7:0]  i_mod,
    input wire [7:0]  i_key_0,
    input wire [7:0]  i_key_1,
    input wire [7:0]  i_key_2,
    input wire [7:0]  i_key_3,
    input wire [7:0]  i_key_4,
    input wire [7:0]  i_key_5,
    input wire [7:0]  i_dx,
    input wire [7:0]  i_dy
);

    logic w_keys_zero;
    logic w_err_kind;

    assign w_keys_zero = (i_key_0 == '0) && (i_key_1 == '0) && (i_key_2 == '0)
                      && (i_key_3 == '0) && (i_key_4 == '0) && (i_key_5 == '0);
    assign w_err_kind  = (i_status == ST_IGNORED) || (i_status == ST_CSUM_ERR)
                      || (i_status == ST_OVERFLOW);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("report dropped or changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_KEYBOARD) || (i_status == ST_MOUSE) || w_err_kind)
        else $error("report status out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_err_kind |->
            (i_mod == '0) && w_keys_zero && (i_dx == '0) && (i_dy == '0))
        else $error("non-data report carries data");

    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_status != ST_KEYBOARD) || ((i_dx == '0) && (i_dy == '0)))
            && ((i_status != ST_MOUSE) || w_keys_zero))
        else $error("keyboard report with motion or mouse report with keys");

endmodule

bind hid_command_frame_deframer_core hidfd_checker u_hidfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rpt.valid),
    .i_out_ready (o_rpt.ready),
    .i_status    (o_rpt.status),
    .i_mod       (o_rpt.mod_or_buttons),
    .i_key_0     (o_rpt.key_0),
    .i_key_1     (o_rpt.key_1),
    .i_key_2     (o_rpt.key_2),
    .i_key_3     (o_rpt.key_3),
    .i_key_4     (o_rpt.key_4),
    .i_key_5     (o_rpt.key_5),
    .i_dx        (o_rpt.delta_x),
    .i_dy        (o_rpt.delta_y)
);

`default_nettype wire
